@@ rtl/nfp_pkg.sv @@
// package: types, constants and helpers for the nav frame parser
`default_nettype none
package nfp_pkg;

  localparam logic [5:0] SOL_BYTES = 6'd52;
  localparam logic [5:0] POS_BYTES = 6'd28;
  localparam logic [5:0] VEL_BYTES = 6'd36;

  localparam logic [7:0] SYNC_1   = 8'hB5;
  localparam logic [7:0] SYNC_2   = 8'h62;
  localparam logic [7:0] NAV_CLS  = 8'h01;
  localparam logic [7:0] ID_SOL   = 8'h06;
  localparam logic [7:0] ID_POS   = 8'h02;
  localparam logic [7:0] ID_VEL   = 8'h12;

  localparam logic [1:0] SLOT_SOL = 2'd0;
  localparam logic [1:0] SLOT_POS = 2'd1;
  localparam logic [1:0] SLOT_VEL = 2'd2;

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_CONSUME = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_SYNC   = 4'd1,
    PH_CLASS  = 4'd2,
    PH_ID     = 4'd3,
    PH_LEN_LO = 4'd4,
    PH_LEN_HI = 4'd5,
    PH_DATA   = 4'd6,
    PH_CK_A   = 4'd7,
    PH_CK_B   = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    ST_INVALID = 2'd0,
    ST_NEW     = 2'd1,
    ST_DONE    = 2'd2
  } slot_state_t;

  typedef struct packed {
    logic        write_valid;
    logic [1:0]  write_slot;
    logic [5:0]  write_offset;
    logic [7:0]  write_data;
    logic        frame_done;
    logic        frame_ok;
    logic        frame_dropped;
    logic        dataset_ready;
    logic [15:0] dataset_count;
  } result_t;

  function automatic logic [5:0] record_size(input logic [1:0] slot);
    logic [5:0] size;
    unique case (slot)
      SLOT_SOL: size = SOL_BYTES;
      SLOT_POS: size = POS_BYTES;
      default:  size = VEL_BYTES;
    endcase
    return size;
  endfunction

endpackage
`default_nettype wire

@@ rtl/nfp_if.sv @@
// channel interfaces for input items and result items
`default_nettype none
interface nfp_item_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface nfp_result_if;
  logic        valid;
  logic        ready;
  logic        write_valid;
  logic [1:0]  write_slot;
  logic [5:0]  write_offset;
  logic [7:0]  write_data;
  logic        frame_done;
  logic        frame_ok;
  logic        frame_dropped;
  logic        dataset_ready;
  logic [15:0] dataset_count;

  modport source (
    output valid, output write_valid, output write_slot, output write_offset,
    output write_data, output frame_done, output frame_ok, output frame_dropped,
    output dataset_ready, output dataset_count, input ready
  );
  modport sink (
    input valid, input write_valid, input write_slot, input write_offset,
    input write_data, input frame_done, input frame_ok, input frame_dropped,
    input dataset_ready, input dataset_count, output ready
  );
endinterface
`default_nettype wire

@@ rtl/nav_frame_parser_fletcher_top.sv @@
// top level: nav frame parser with fletcher-8 check and result register
//
// item channel: one transaction per received serial byte (kind 0, rx_byte)
// or per host consume notice (kind 1). result channel: exactly one
// transaction per item, carrying a slot write strobe with slot, offset and
// data, the frame done/ok/dropped flags, dataset ready and the count.
// result valid rises in the cycle after the item transaction. throughput is
// one item per cycle while results drain: the parser state updates in the
// cycle of the item transaction and the result lands in a single output
// register. item ready is high while the output register is empty or being
// drained, so a stalled receiver holds its result and stops new items only
// then. reset clears the parser to hunting for sync, marks all three slots
// invalid, clears the pending flag and the dataset counter, and empties
// the output register.
`default_nettype none
module nav_frame_parser_fletcher_top (
  input wire logic     clk,
  input wire logic     rst,
  nfp_item_if.sink     item,
  nfp_result_if.source result
);

  nfp_pkg::result_t res_comb;
  nfp_pkg::result_t res_reg;
  logic             res_valid;
  logic             step;

  assign item.ready = !res_valid || result.ready;
  assign step       = item.valid && item.ready;

  nfp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .kind    (item.kind),
    .rx_byte (item.rx_byte),
    .res     (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (item.ready) begin
      res_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_reg <= res_comb;
    end
  end

  assign result.valid         = res_valid;
  assign result.write_valid   = res_reg.write_valid;
  assign result.write_slot    = res_reg.write_slot;
  assign result.write_offset  = res_reg.write_offset;
  assign result.write_data    = res_reg.write_data;
  assign result.frame_done    = res_reg.frame_done;
  assign result.frame_ok      = res_reg.frame_ok;
  assign result.frame_dropped = res_reg.frame_dropped;
  assign result.dataset_ready = res_reg.dataset_ready;
  assign result.dataset_count = res_reg.dataset_count;

endmodule
`default_nettype wire

@@ rtl/nfp_parser.sv @@
// frame parser state, fletcher sum, slot status and dataset publishing
`default_nettype none
module nfp_parser (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic             kind,
  input  wire logic [7:0]       rx_byte,
  output nfp_pkg::result_t      res
);

  nfp_pkg::phase_t      phase, phase_next;
  logic [7:0]           sum_a, sum_a_next;
  logic [7:0]           sum_b, sum_b_next;
  logic [15:0]          bytes_left, bytes_left_next;
  logic [1:0]           active_slot, active_slot_next;
  logic [5:0]           next_offset, next_offset_next;
  nfp_pkg::slot_state_t slot_status [3];
  nfp_pkg::slot_state_t slot_status_next [3];
  logic                 info_pending, info_pending_next;
  logic [15:0]          set_counter, set_counter_next;

  logic [1:0] slot;
  logic       id_match;
  logic [7:0] sum_a_add;
  logic       pub_req;

  assign slot      = (active_slot > nfp_pkg::SLOT_VEL) ? nfp_pkg::SLOT_VEL : active_slot;
  assign id_match  = (rx_byte == nfp_pkg::ID_SOL) || (rx_byte == nfp_pkg::ID_POS) ||
                     (rx_byte == nfp_pkg::ID_VEL);
  assign sum_a_add = sum_a + rx_byte;

  // next phase
  always_comb begin
    phase_next = phase;
    if (kind == nfp_pkg::KIND_BYTE) begin
      unique case (phase)
        nfp_pkg::PH_IDLE:
          phase_next = (rx_byte == nfp_pkg::SYNC_1) ? nfp_pkg::PH_SYNC : nfp_pkg::PH_IDLE;
        nfp_pkg::PH_SYNC:
          phase_next = (rx_byte == nfp_pkg::SYNC_2) ? nfp_pkg::PH_CLASS : nfp_pkg::PH_IDLE;
        nfp_pkg::PH_CLASS:
          phase_next = (rx_byte == nfp_pkg::NAV_CLS) ? nfp_pkg::PH_ID : nfp_pkg::PH_IDLE;
        nfp_pkg::PH_ID:
          phase_next = id_match ? nfp_pkg::PH_LEN_LO : nfp_pkg::PH_IDLE;
        nfp_pkg::PH_LEN_LO:
          phase_next = nfp_pkg::PH_LEN_HI;
        nfp_pkg::PH_LEN_HI: begin
          if (slot_status[slot] == nfp_pkg::ST_NEW) begin
            phase_next = nfp_pkg::PH_IDLE;
          end else if ({rx_byte, bytes_left[7:0]} == 16'd0) begin
            phase_next = nfp_pkg::PH_CK_A;
          end else begin
            phase_next = nfp_pkg::PH_DATA;
          end
        end
        nfp_pkg::PH_DATA:
          phase_next = (bytes_left == 16'd1) ? nfp_pkg::PH_CK_A : nfp_pkg::PH_DATA;
        nfp_pkg::PH_CK_A:
          phase_next = (rx_byte == sum_a) ? nfp_pkg::PH_CK_B : nfp_pkg::PH_IDLE;
        nfp_pkg::PH_CK_B:
          phase_next = nfp_pkg::PH_IDLE;
        default:
          phase_next = nfp_pkg::PH_IDLE;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    sum_a_next        = sum_a;
    sum_b_next        = sum_b;
    bytes_left_next   = bytes_left;
    active_slot_next  = active_slot;
    next_offset_next  = next_offset;
    slot_status_next  = slot_status;
    info_pending_next = info_pending;
    set_counter_next  = set_counter;
    pub_req           = 1'b0;
    res               = '0;
    if (kind == nfp_pkg::KIND_CONSUME) begin
      info_pending_next = 1'b0;
    end else begin
      unique case (phase)
        nfp_pkg::PH_ID: begin
          if (id_match) begin
            if (rx_byte == nfp_pkg::ID_SOL) begin
              active_slot_next = nfp_pkg::SLOT_SOL;
            end else if (rx_byte == nfp_pkg::ID_POS) begin
              active_slot_next = nfp_pkg::SLOT_POS;
            end else begin
              active_slot_next = nfp_pkg::SLOT_VEL;
            end
            sum_a_next = nfp_pkg::NAV_CLS + rx_byte;
            sum_b_next = nfp_pkg::NAV_CLS + nfp_pkg::NAV_CLS + rx_byte;
          end
        end
        nfp_pkg::PH_LEN_LO: begin
          bytes_left_next = {8'd0, rx_byte};
          sum_a_next      = sum_a_add;
          sum_b_next      = sum_b + sum_a_add;
        end
        nfp_pkg::PH_LEN_HI: begin
          bytes_left_next = {rx_byte, bytes_left[7:0]};
          sum_a_next      = sum_a_add;
          sum_b_next      = sum_b + sum_a_add;
          if (slot_status[slot] == nfp_pkg::ST_NEW) begin
            pub_req           = 1'b1;
            res.frame_dropped = 1'b1;
          end else begin
            slot_status_next[slot] = nfp_pkg::ST_INVALID;
            next_offset_next       = 6'd0;
          end
        end
        nfp_pkg::PH_DATA: begin
          if (next_offset < nfp_pkg::record_size(slot)) begin
            res.write_valid  = 1'b1;
            res.write_slot   = slot;
            res.write_offset = next_offset;
            res.write_data   = rx_byte;
            next_offset_next = next_offset + 6'd1;
          end
          sum_a_next      = sum_a_add;
          sum_b_next      = sum_b + sum_a_add;
          bytes_left_next = bytes_left - 16'd1;
        end
        nfp_pkg::PH_CK_A: begin
          if (rx_byte != sum_a) begin
            slot_status_next[slot] = nfp_pkg::ST_INVALID;
            res.frame_done         = 1'b1;
          end
        end
        nfp_pkg::PH_CK_B: begin
          res.frame_done = 1'b1;
          if (rx_byte == sum_b) begin
            res.frame_ok           = 1'b1;
            slot_status_next[slot] = nfp_pkg::ST_NEW;
            pub_req                = 1'b1;
          end else begin
            slot_status_next[slot] = nfp_pkg::ST_INVALID;
          end
        end
        default: begin
        end
      endcase
      if (pub_req && slot_status_next[0] == nfp_pkg::ST_NEW &&
          slot_status_next[1] == nfp_pkg::ST_NEW &&
          slot_status_next[2] == nfp_pkg::ST_NEW) begin
        if (!info_pending) begin
          set_counter_next  = set_counter + 16'd1;
          info_pending_next = 1'b1;
          res.dataset_ready = 1'b1;
        end
        slot_status_next[0] = nfp_pkg::ST_DONE;
        slot_status_next[1] = nfp_pkg::ST_DONE;
        slot_status_next[2] = nfp_pkg::ST_DONE;
      end
    end
    res.dataset_count = set_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= nfp_pkg::PH_IDLE;
      sum_a          <= 8'd0;
      sum_b          <= 8'd0;
      bytes_left     <= 16'd0;
      active_slot    <= 2'd0;
      next_offset    <= 6'd0;
      slot_status[0] <= nfp_pkg::ST_INVALID;
      slot_status[1] <= nfp_pkg::ST_INVALID;
      slot_status[2] <= nfp_pkg::ST_INVALID;
      info_pending   <= 1'b0;
      set_counter    <= 16'd0;
    end else if (step) begin
      phase        <= phase_next;
      sum_a        <= sum_a_next;
      sum_b        <= sum_b_next;
      bytes_left   <= bytes_left_next;
      active_slot  <= active_slot_next;
      next_offset  <= next_offset_next;
      slot_status  <= slot_status_next;
      info_pending <= info_pending_next;
      set_counter  <= set_counter_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/nfp_checker.sv @@
// port-level checker for the nav frame parser, bound to the top level
`default_nettype none
module nfp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        item_valid,
  input wire logic        item_ready,
  input wire logic        result_valid,
  input wire logic        result_ready,
  input wire logic        write_valid,
  input wire logic [1:0]  write_slot,
  input wire logic        frame_done,
  input wire logic        frame_ok,
  input wire logic        frame_dropped,
  input wire logic        dataset_ready,
  input wire logic [15:0] dataset_count
);

  a_one_result_per_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> result_valid)
    else $error("accepted item produced no result");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(dataset_count))
    else $error("stalled result changed");

  a_write_alone: assert property (@(posedge clk) disable iff (rst)
    result_valid && write_valid |->
      !frame_done && !frame_dropped && !dataset_ready && write_slot != 2'd3)
    else $error("slot write combined with frame event");

  a_ok_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && frame_ok |-> frame_done && !frame_dropped)
    else $error("frame ok without frame done");

  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    result_valid && dataset_ready |-> frame_ok || frame_dropped)
    else $error("dataset ready without frame end");

endmodule

bind nav_frame_parser_fletcher_top nfp_checker u_nfp_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item.valid),
  .item_ready    (item.ready),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .write_valid   (result.write_valid),
  .write_slot    (result.write_slot),
  .frame_done    (result.frame_done),
  .frame_ok      (result.frame_ok),
  .frame_dropped (result.frame_dropped),
  .dataset_ready (result.dataset_ready),
  .dataset_count (result.dataset_count)
);
`default_nettype wire

@@ verif/testbench.sv @@
// testbench for the nav frame parser: directed and random byte streams checked against a local parser model
`timescale 1ns / 1ps
module testbench;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_CK_A,
    FRAME_BAD_CK_B,
    FRAME_CUT,
    FRAME_HEADER_ONLY
  } frame_fault_t;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned RANDOM_ITEMS = 1300;

  logic clk = 1'b0;
  logic rst;

  nfp_item_if item_if ();
  nfp_result_if result_if ();

  nav_frame_parser_fletcher_top u_dut (
    .clk(clk),
    .rst(rst),
    .item(item_if),
    .result(result_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  nfp_pkg::result_t parser_outputs_q[$];
  int unsigned items_sent = 0;
  int unsigned mismatches = 0;
  bit steady_rate = 1'b0;

  nfp_pkg::phase_t      ph;
  logic [7:0]           fa;
  logic [7:0]           fb;
  logic [15:0]          remaining;
  logic [1:0]           cur_slot;
  logic [5:0]           wr_offset;
  nfp_pkg::slot_state_t rec_state [3];
  logic                 host_busy;
  logic [15:0]          sets_published;

  function automatic void reset_parser_model();
    ph = nfp_pkg::PH_IDLE;
    fa = '0;
    fb = '0;
    remaining = '0;
    cur_slot = nfp_pkg::SLOT_SOL;
    wr_offset = '0;
    for (int i = 0; i < 3; i++) rec_state[i] = nfp_pkg::ST_INVALID;
    host_busy = 1'b0;
    sets_published = '0;
  endfunction

  function automatic int unsigned slot_bytes(input logic [1:0] slot);
    case (slot)
      nfp_pkg::SLOT_SOL: return int'(nfp_pkg::SOL_BYTES);
      nfp_pkg::SLOT_POS: return int'(nfp_pkg::POS_BYTES);
      default:           return int'(nfp_pkg::VEL_BYTES);
    endcase
  endfunction

  function automatic void fletcher_add(input logic [7:0] c);
    fa = fa + c;
    fb = fb + fa;
  endfunction

  function automatic logic publish_dataset();
    logic published;
    published = 1'b0;
    if (rec_state[0] == nfp_pkg::ST_NEW && rec_state[1] == nfp_pkg::ST_NEW &&
        rec_state[2] == nfp_pkg::ST_NEW) begin
      if (!host_busy) begin
        sets_published = sets_published + 16'd1;
        host_busy = 1'b1;
        published = 1'b1;
      end
      for (int i = 0; i < 3; i++) rec_state[i] = nfp_pkg::ST_DONE;
    end
    return published;
  endfunction

  function automatic nfp_pkg::result_t parse_step(input logic k, input logic [7:0] c);
    nfp_pkg::result_t r;
    logic [1:0] slot;
    r = '0;
    slot = (cur_slot > nfp_pkg::SLOT_VEL) ? nfp_pkg::SLOT_VEL : cur_slot;
    if (k == nfp_pkg::KIND_CONSUME) begin
      host_busy = 1'b0;
    end else begin
      case (ph)
        nfp_pkg::PH_IDLE: ph = (c == nfp_pkg::SYNC_1) ? nfp_pkg::PH_SYNC : nfp_pkg::PH_IDLE;
        nfp_pkg::PH_SYNC: ph = (c == nfp_pkg::SYNC_2) ? nfp_pkg::PH_CLASS : nfp_pkg::PH_IDLE;
        nfp_pkg::PH_CLASS: ph = (c == nfp_pkg::NAV_CLS) ? nfp_pkg::PH_ID : nfp_pkg::PH_IDLE;
        nfp_pkg::PH_ID: begin
          if (c == nfp_pkg::ID_SOL || c == nfp_pkg::ID_POS || c == nfp_pkg::ID_VEL) begin
            cur_slot = (c == nfp_pkg::ID_SOL) ? nfp_pkg::SLOT_SOL :
                       (c == nfp_pkg::ID_POS) ? nfp_pkg::SLOT_POS : nfp_pkg::SLOT_VEL;
            fa = nfp_pkg::NAV_CLS + c;
            fb = nfp_pkg::NAV_CLS + fa;
            ph = nfp_pkg::PH_LEN_LO;
          end else begin
            ph = nfp_pkg::PH_IDLE;
          end
        end
        nfp_pkg::PH_LEN_LO: begin
          remaining = {8'h00, c};
          fletcher_add(c);
          ph = nfp_pkg::PH_LEN_HI;
        end
        nfp_pkg::PH_LEN_HI: begin
          remaining[15:8] = c;
          fletcher_add(c);
          if (rec_state[slot] == nfp_pkg::ST_NEW) begin
            r.dataset_ready = publish_dataset();
            r.frame_dropped = 1'b1;
            ph = nfp_pkg::PH_IDLE;
          end else begin
            rec_state[slot] = nfp_pkg::ST_INVALID;
            wr_offset = '0;
            ph = (remaining == 16'd0) ? nfp_pkg::PH_CK_A : nfp_pkg::PH_DATA;
          end
        end
        nfp_pkg::PH_DATA: begin
          if (int'(wr_offset) < slot_bytes(slot)) begin
            r.write_valid = 1'b1;
            r.write_slot = slot;
            r.write_offset = wr_offset;
            r.write_data = c;
            wr_offset = wr_offset + 6'd1;
          end
          fletcher_add(c);
          remaining = remaining - 16'd1;
          if (remaining == 16'd0) ph = nfp_pkg::PH_CK_A;
        end
        nfp_pkg::PH_CK_A: begin
          if (c == fa) begin
            ph = nfp_pkg::PH_CK_B;
          end else begin
            rec_state[slot] = nfp_pkg::ST_INVALID;
            r.frame_done = 1'b1;
            ph = nfp_pkg::PH_IDLE;
          end
        end
        nfp_pkg::PH_CK_B: begin
          r.frame_done = 1'b1;
          if (c == fb) begin
            r.frame_ok = 1'b1;
            rec_state[slot] = nfp_pkg::ST_NEW;
            r.dataset_ready = publish_dataset();
          end else begin
            rec_state[slot] = nfp_pkg::ST_INVALID;
          end
          ph = nfp_pkg::PH_IDLE;
        end
        default: ph = nfp_pkg::PH_IDLE;
      endcase
    end
    r.dataset_count = sets_published;
    return r;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_rate || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input logic k, input logic [7:0] b);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_if.valid <= 1'b1;
    item_if.kind <= k;
    item_if.rx_byte <= b;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    parser_outputs_q.push_back(parse_step(k, b));
    items_sent++;
  endtask

  task automatic wait_results_drained();
    item_if.valid <= 1'b0;
    while (parser_outputs_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_frame(input logic [7:0] id, input logic [15:0] len,
                            input frame_fault_t fault);
    logic [7:0] bytes_q[$];
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    int unsigned keep;
    bytes_q.push_back(nfp_pkg::SYNC_1);
    bytes_q.push_back(nfp_pkg::SYNC_2);
    bytes_q.push_back(nfp_pkg::NAV_CLS);
    bytes_q.push_back(id);
    bytes_q.push_back(len[7:0]);
    bytes_q.push_back(len[15:8]);
    if (fault != FRAME_HEADER_ONLY) begin
      for (int unsigned i = 0; i < len; i++) bytes_q.push_back(8'($urandom));
      ck_a = '0;
      ck_b = '0;
      for (int i = 2; i < bytes_q.size(); i++) begin
        ck_a = ck_a + bytes_q[i];
        ck_b = ck_b + ck_a;
      end
      if (fault == FRAME_BAD_CK_A) ck_a = ck_a ^ 8'($urandom_range(1, 255));
      if (fault == FRAME_BAD_CK_B) ck_b = ck_b ^ 8'($urandom_range(1, 255));
      bytes_q.push_back(ck_a);
      bytes_q.push_back(ck_b);
    end
    keep = bytes_q.size();
    if (fault == FRAME_CUT) keep = $urandom_range(1, bytes_q.size() - 1);
    for (int unsigned i = 0; i < keep; i++) begin
      if ($urandom_range(0, 24) == 0) send_item(nfp_pkg::KIND_CONSUME, 8'($urandom));
      send_item(nfp_pkg::KIND_BYTE, bytes_q[i]);
    end
  endtask

  task automatic send_noise();
    logic [7:0] sync_seq [3];
    sync_seq[0] = nfp_pkg::SYNC_1;
    sync_seq[1] = nfp_pkg::SYNC_2;
    sync_seq[2] = nfp_pkg::NAV_CLS;
    for (int i = 0; i < int'($urandom_range(0, 3)); i++) begin
      send_item(nfp_pkg::KIND_BYTE, sync_seq[i]);
    end
    repeat ($urandom_range(1, 5)) send_item(nfp_pkg::KIND_BYTE, 8'($urandom));
  endtask

  function automatic logic [15:0] pick_len(input logic [1:0] slot);
    int unsigned r;
    int unsigned size;
    r = $urandom_range(0, 99);
    size = slot_bytes(slot);
    if (r < 35) return 16'(size);
    if (r < 65) return 16'($urandom_range(0, size));
    if (r < 90) return 16'($urandom_range(size + 1, 64));
    if (r < 97) return 16'($urandom_range(0, 3));
    return 16'($urandom_range(250, 300));
  endfunction

  task automatic test_idle_noise();
    send_item(nfp_pkg::KIND_CONSUME, 8'hFF);
    send_item(nfp_pkg::KIND_BYTE, 8'h00);
    send_item(nfp_pkg::KIND_BYTE, 8'hFF);
    send_item(nfp_pkg::KIND_BYTE, nfp_pkg::SYNC_1);
    send_item(nfp_pkg::KIND_BYTE, 8'h00);
    send_frame(8'h07, 16'h0000, FRAME_HEADER_ONLY);
  endtask

  task automatic test_empty_frames_publish();
    send_frame(nfp_pkg::ID_SOL, 16'd0, FRAME_GOOD);
    send_frame(nfp_pkg::ID_POS, 16'd0, FRAME_GOOD);
    send_frame(nfp_pkg::ID_VEL, 16'd0, FRAME_GOOD);
  endtask

  task automatic test_pending_drop();
    send_frame(nfp_pkg::ID_POS, 16'd0, FRAME_GOOD);
    send_frame(nfp_pkg::ID_POS, 16'hFFFF, FRAME_HEADER_ONLY);
  endtask

  task automatic test_checksum_errors();
    send_frame(nfp_pkg::ID_VEL, 16'd0, FRAME_BAD_CK_A);
    send_frame(nfp_pkg::ID_SOL, 16'd0, FRAME_BAD_CK_B);
  endtask

  task automatic test_hold_until_consumed();
    send_frame(nfp_pkg::ID_SOL, 16'd0, FRAME_GOOD);
    send_frame(nfp_pkg::ID_VEL, 16'd0, FRAME_GOOD);
    send_item(nfp_pkg::KIND_CONSUME, 8'h00);
    wait_results_drained();
  endtask

  task automatic test_random_stream();
    int unsigned stop_at;
    int unsigned r;
    logic [7:0] id;
    logic [1:0] slot;
    frame_fault_t fault;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        r = $urandom_range(0, 99);
        id = (r < 32) ? nfp_pkg::ID_SOL : (r < 64) ? nfp_pkg::ID_POS :
             (r < 96) ? nfp_pkg::ID_VEL : 8'($urandom);
        slot = (id == nfp_pkg::ID_SOL) ? nfp_pkg::SLOT_SOL :
               (id == nfp_pkg::ID_POS) ? nfp_pkg::SLOT_POS : nfp_pkg::SLOT_VEL;
        r = $urandom_range(0, 99);
        fault = (r < 80) ? FRAME_GOOD : (r < 87) ? FRAME_BAD_CK_A :
                (r < 94) ? FRAME_BAD_CK_B : FRAME_CUT;
        send_frame(id, pick_len(slot), fault);
      end else if (r < 82) begin
        send_noise();
      end else if (r < 92) begin
        send_item(nfp_pkg::KIND_CONSUME, 8'($urandom));
      end else if (r < 98) begin
        steady_rate = ($urandom_range(0, 3) == 0);
      end else begin
        wait_results_drained();
      end
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    nfp_pkg::result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (parser_outputs_q.size() == 0) begin
        $error("result transaction with no prediction waiting");
        mismatches++;
      end else begin
        want = parser_outputs_q.pop_front();
        check_field("write_valid", 16'(want.write_valid), 16'(result_if.write_valid));
        check_field("write_slot", 16'(want.write_slot), 16'(result_if.write_slot));
        check_field("write_offset", 16'(want.write_offset), 16'(result_if.write_offset));
        check_field("write_data", 16'(want.write_data), 16'(result_if.write_data));
        check_field("frame_done", 16'(want.frame_done), 16'(result_if.frame_done));
        check_field("frame_ok", 16'(want.frame_ok), 16'(result_if.frame_ok));
        check_field("frame_dropped", 16'(want.frame_dropped),
                    16'(result_if.frame_dropped));
        check_field("dataset_ready", 16'(want.dataset_ready),
                    16'(result_if.dataset_ready));
        check_field("dataset_count", want.dataset_count, result_if.dataset_count);
      end
    end
  end

  initial begin : result_pacing
    int unsigned n;
    forever begin
      result_if.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      n = idle_len();
      if (n != 0) begin
        result_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    wait (rst === 1'b0);
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("nav_frame_parser_fletcher_top regression: fail");
    $finish;
  end

  initial begin
    reset_parser_model();
    rst <= 1'b1;
    item_if.valid <= 1'b0;
    item_if.kind <= nfp_pkg::KIND_BYTE;
    item_if.rx_byte <= 8'h00;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_noise();
    test_empty_frames_publish();
    test_pending_drop();
    test_checksum_errors();
    test_hold_until_consumed();
    test_random_stream();
    wait_results_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("nav_frame_parser_fletcher_top regression: pass");
    end else begin
      $display("nav_frame_parser_fletcher_top regression: fail");
    end
    $finish;
  end

endmodule
